// File: hdl/spd_pkg.sv
// package for the stroke point decimator: widths, constants, command and status types
// no dependencies
`default_nettype none
package spd_pkg;
  localparam int unsigned COORD_BITS_DEF  = 12;
  localparam int unsigned FRAC_BITS_DEF   = 4;
  localparam int unsigned SHORT_LIMIT_DEF = 4;
  localparam int unsigned THR_W   = 16;
  localparam int unsigned ACC_W   = 20;
  localparam logic [THR_W-1:0] THR_RESET = 16'd80;
  localparam logic [ACC_W-1:0] ACC_MAX   = {ACC_W{1'b1}};

  // emit source selects
  typedef enum logic [1:0] {
    SRC_HEAD = 2'd0,
    SRC_CUR  = 2'd1
  } src_sel_t;

  typedef struct packed {
    logic     load;      // capture input word, start step length
    logic     sqrt_step; // one root iteration
    logic     commit;    // update accumulator / marks / head store
    logic     emit_load; // load output register
    src_sel_t src;
    logic [2:0] head_idx;
    logic     done_bit;
    logic     last_bit;
    logic     end_clear;
  } spd_cmd_t;

  typedef struct packed {
    logic       sqrt_busy;
    logic       judge_hit;
    logic       last_pt;
    logic [3:0] seen;
    logic [7:0] marks;
  } spd_sts_t;
endpackage
`default_nettype wire

// File: hdl/spd_if.sv
// valid/ready channel interface carrying one payload word
// depends on nothing
`default_nettype none
interface spd_if #(parameter int unsigned W = 1) (input wire logic clk);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/spd_datapath.sv
// datapath: head store, previous point, step length root unit, accumulator, output register
// depends on spd_pkg
`default_nettype none
module spd_datapath #(
  parameter int unsigned COORD_BITS  = spd_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS   = spd_pkg::FRAC_BITS_DEF,
  parameter int unsigned SHORT_LIMIT = spd_pkg::SHORT_LIMIT_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic [COORD_BITS-1:0]      in_x,
  input  wire logic [COORD_BITS-1:0]      in_y,
  input  wire logic                       in_end,
  input  wire logic [spd_pkg::THR_W-1:0]  thr,
  input  wire spd_pkg::spd_cmd_t          cmd,
  output spd_pkg::spd_sts_t               sts,
  output logic [COORD_BITS-1:0]           o_x,
  output logic [COORD_BITS-1:0]           o_y,
  output logic                            o_done,
  output logic                            o_last
);
  import spd_pkg::*;
  localparam int unsigned PW  = 2*COORD_BITS;
  localparam int unsigned SQW = 2*COORD_BITS + 1 + 2*FRAC_BITS;
  localparam int unsigned RTW = (SQW+1)/2 + 1;
  localparam int unsigned NST = (SQW+1)/2;
  localparam int unsigned CW  = $clog2(NST+1);
  localparam int unsigned HW  = $clog2(SHORT_LIMIT);
  localparam int unsigned RAW = 2*RTW + 2;

  logic [PW-1:0] head_r [SHORT_LIMIT];
  logic [PW-1:0] cur_r, prev_r;
  logic          last_r;
  logic [RAW-1:0] rem_r, rem_nxt;
  logic [RTW-1:0] root_r, root_nxt;
  logic [CW-1:0]  cnt_r;
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [SHORT_LIMIT-1:0] marks_r, marks_nxt;
  logic [3:0]     seen_r, seen_nxt;
  logic [2*NST-1:0] sq_r;
  logic [COORD_BITS-1:0] dx, dy;
  logic [2*COORD_BITS:0] sqs;
  logic hit;

  assign dx  = (in_x > prev_r[COORD_BITS-1:0]) ? in_x - prev_r[COORD_BITS-1:0]
                                               : prev_r[COORD_BITS-1:0] - in_x;
  assign dy  = (in_y > prev_r[PW-1:COORD_BITS]) ? in_y - prev_r[PW-1:COORD_BITS]
                                                : prev_r[PW-1:COORD_BITS] - in_y;
  assign sqs = (2*COORD_BITS+1)'(dx*dx) + (2*COORD_BITS+1)'(dy*dy);
  assign hit = acc_r > ACC_W'(thr);

  // restoring root, two bits of the square per cycle, msb first
  always_comb begin
    logic [RAW-1:0] t;
    logic [RAW-1:0] r2;
    r2  = {rem_r[RAW-3:0], 2'b00} | RAW'(sq_r[2*NST-1 -: 2]);
    t   = {root_r, 2'b01};
    rem_nxt  = rem_r;
    root_nxt = root_r;
    if (r2 >= RAW'(t)) begin
      rem_nxt  = r2 - RAW'(t);
      root_nxt = {root_r[RTW-2:0], 1'b1};
    end else begin
      rem_nxt  = r2;
      root_nxt = {root_r[RTW-2:0], 1'b0};
    end
  end

  always_comb begin
    logic [ACC_W:0] s;
    acc_nxt   = acc_r;
    marks_nxt = marks_r;
    seen_nxt  = seen_r;
    s = (ACC_W+1)'(acc_r) + (ACC_W+1)'(root_r);
    if (seen_r == 4'd0) begin
      acc_nxt = '0;
      marks_nxt = SHORT_LIMIT'(1);
    end else if (hit) begin
      acc_nxt = '0;
      if (seen_r < 4'(SHORT_LIMIT)) marks_nxt[seen_r[HW-1:0]] = 1'b1;
    end else begin
      acc_nxt = s[ACC_W] ? ACC_MAX : s[ACC_W-1:0];
    end
    if (seen_r <= 4'(SHORT_LIMIT)) seen_nxt = seen_r + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0; marks_r <= '0; seen_r <= '0; cnt_r <= '0;
    end else begin
      if (cmd.load) begin
        cur_r  <= {in_y, in_x};
        last_r <= in_end;
        sq_r   <= (2*NST)'({sqs, {(2*FRAC_BITS){1'b0}}});
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
      end else if (cmd.sqrt_step) begin
        rem_r  <= rem_nxt;
        root_r <= root_nxt;
        sq_r   <= {sq_r[2*NST-3:0], 2'b00};
        cnt_r  <= cnt_r + CW'(1);
      end
      if (cmd.commit) begin
        acc_r   <= acc_nxt;
        marks_r <= marks_nxt;
        seen_r  <= seen_nxt;
        prev_r  <= cur_r;
        if (seen_r < 4'(SHORT_LIMIT)) head_r[seen_r[HW-1:0]] <= cur_r;
      end
      if (cmd.end_clear) begin
        acc_r <= '0; marks_r <= '0; seen_r <= '0;
      end
      if (cmd.emit_load) begin
        if (cmd.src == SRC_HEAD) begin
          o_x <= head_r[cmd.head_idx[HW-1:0]][COORD_BITS-1:0];
          o_y <= head_r[cmd.head_idx[HW-1:0]][PW-1:COORD_BITS];
        end else begin
          o_x <= cur_r[COORD_BITS-1:0];
          o_y <= cur_r[PW-1:COORD_BITS];
        end
        o_done <= cmd.done_bit;
        o_last <= cmd.last_bit;
      end
    end
  end

  always_comb begin
    sts = '0;
    sts.sqrt_busy = cnt_r != CW'(NST);
    sts.judge_hit = hit;
    sts.last_pt   = last_r;
    sts.seen      = seen_r;
    sts.marks     = 8'(marks_r);
  end
endmodule
`default_nettype wire

// File: hdl/spd_ctrl.sv
// controller: sequences load, root steps, commit and the emit list of one point
// depends on spd_pkg
`default_nettype none
module spd_ctrl #(
  parameter int unsigned SHORT_LIMIT = spd_pkg::SHORT_LIMIT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire spd_pkg::spd_sts_t sts,
  output spd_pkg::spd_cmd_t      cmd
);
  import spd_pkg::*;
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ROOT = 5'b00010,
    S_PLAN = 5'b00100,
    S_EMIT = 5'b01000,
    S_WAIT = 5'b10000
  } state_t;

  // emit list: 8 slots, source + head index + done
  localparam int unsigned NL = 8;
  state_t state_r, state_nxt;
  logic [NL-1:0] lv_r, lv_nxt;
  logic [NL-1:0] lcur_r, lcur_nxt, ldone_r, ldone_nxt;
  logic [2:0]    lidx_r [NL];
  logic [2:0]    lidx_nxt [NL];
  logic [2:0]    pos_r, pos_nxt;
  logic          ov_r, ov_nxt;
  logic          more;

  always_comb begin
    int unsigned n, c;
    logic [3:0] s;
    state_nxt = state_r; lv_nxt = lv_r; lcur_nxt = lcur_r; ldone_nxt = ldone_r;
    lidx_nxt = lidx_r; pos_nxt = pos_r; ov_nxt = ov_r;
    cmd = '0; cmd.src = SRC_HEAD;
    in_ready = 1'b0;
    more = 1'b0;
    n = 0; c = 0; s = sts.seen;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_ROOT;
        end
      end
      S_ROOT: begin
        if (sts.sqrt_busy) cmd.sqrt_step = 1'b1;
        else state_nxt = S_PLAN;
      end
      S_PLAN: begin
        // build emit list from pre-commit status, then commit
        lv_nxt = '0; lcur_nxt = '0; ldone_nxt = '0;
        if (s < 4'(SHORT_LIMIT)) begin
          if (sts.last_pt) begin
            c = 32'(s) + 1;
            if (c == 1) begin
              lv_nxt[0] = 1'b1; lidx_nxt[0] = 3'd0; ldone_nxt[0] = 1'b1;
            end else begin
              lv_nxt[2:0] = 3'b111;
              lidx_nxt[0] = 3'd0;
              lidx_nxt[1] = 3'((c-1)/2);
              lidx_nxt[2] = 3'(c-1);
              ldone_nxt[2] = 1'b1;
            end
          end
        end else begin
          if (s == 4'(SHORT_LIMIT)) begin
            for (int i = 0; i < SHORT_LIMIT; i++) begin
              if (sts.marks[i]) begin
                lv_nxt[n] = 1'b1; lidx_nxt[n] = 3'(i); n++;
              end
            end
          end
          if (sts.judge_hit) begin
            lv_nxt[n] = 1'b1; lcur_nxt[n] = 1'b1; n++;
          end
          if (sts.last_pt) begin
            lv_nxt[n] = 1'b1; lcur_nxt[n] = 1'b1; ldone_nxt[n] = 1'b1;
          end
        end
        cmd.commit = 1'b1;
        pos_nxt = '0;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // head store writes land before first read
        if (sts.last_pt) cmd.end_clear = 1'b1;
        if (!lv_r[pos_r]) begin
          state_nxt = S_IDLE;
        end else if (!ov_r || out_ready) begin
          more = (pos_r != 3'(NL-1)) && lv_r[pos_r + 3'd1];
          cmd.emit_load = 1'b1;
          cmd.src = lcur_r[pos_r] ? SRC_CUR : SRC_HEAD;
          cmd.head_idx = lidx_r[pos_r];
          cmd.done_bit = ldone_r[pos_r];
          cmd.last_bit = !more;
          ov_nxt = 1'b1;
          pos_nxt = pos_r + 3'd1;
          if (!more) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ov_r <= 1'b0; lv_r <= '0; pos_r <= '0;
      lcur_r <= '0; ldone_r <= '0;
    end else begin
      state_r <= state_nxt; ov_r <= ov_nxt; lv_r <= lv_nxt; pos_r <= pos_nxt;
      lcur_r <= lcur_nxt; ldone_r <= ldone_nxt;
    end
  end
  always_ff @(posedge clk) lidx_r <= lidx_nxt;

  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ready |=> ov_r) else $error("result dropped");
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> state_r == S_IDLE) else $error("load outside idle");
endmodule
`default_nettype wire

// File: hdl/stroke_point_decimator.sv
// top level of the stroke point decimator: channels, threshold register, ctrl and datapath
// depends on spd_pkg, spd_if, spd_ctrl, spd_datapath
//  channel | dir | payload
//  in_     | in  | point_x, point_y, stroke_end
//  out_    | out | out_x, out_y, stroke_done, run_last
//  cfg_    | in  | dist_threshold
// one point is accepted, then its step length is found by the two-bit-per-cycle square
// root, then the emit list is planned and its results (possibly none) are sent out.
// results are registered; a stalled output holds the emit sequence and with it the
// input.
// reset: synchronous rst_n, threshold returns to 80.
`default_nettype none
module stroke_point_decimator #(
  parameter int unsigned COORD_BITS  = spd_pkg::COORD_BITS_DEF,
  parameter int unsigned FRAC_BITS   = spd_pkg::FRAC_BITS_DEF,
  parameter int unsigned SHORT_LIMIT = spd_pkg::SHORT_LIMIT_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  spd_if.sink        in_ch,
  spd_if.source      out_ch,
  spd_if.sink        cfg_ch
);
  import spd_pkg::*;
  logic [THR_W-1:0] thr_r;
  spd_cmd_t cmd;
  spd_sts_t sts;
  logic [COORD_BITS-1:0] ox, oy;
  logic od, ol;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) thr_r <= THR_RESET;
    else if (cfg_ch.valid) thr_r <= cfg_ch.data[THR_W-1:0];
  end

  spd_ctrl #(.SHORT_LIMIT(SHORT_LIMIT)) u_ctrl (
    .clk, .rst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .sts, .cmd);

  spd_datapath #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS),
                 .SHORT_LIMIT(SHORT_LIMIT)) u_dp (
    .clk, .rst_n,
    .in_x(in_ch.data[COORD_BITS-1:0]),
    .in_y(in_ch.data[2*COORD_BITS-1:COORD_BITS]),
    .in_end(in_ch.data[2*COORD_BITS]),
    .thr(thr_r), .cmd, .sts, .o_x(ox), .o_y(oy), .o_done(od), .o_last(ol));

  // out word: {run_last, stroke_done, y, x}
  assign out_ch.data = {ol, od, oy, ox};
endmodule
`default_nettype wire

// File: tb/tb.sv
// testbench for stroke_point_decimator: drives pen stroke points, predicts the thinned points
// depends on spd_pkg, spd_if and the stroke_point_decimator rtl
`default_nettype none
module tb;
  import spd_pkg::*;

  localparam int CB = 12;
  localparam int IN_W = 2*CB + 1;
  localparam int OUT_W = 2*CB + 2;

  typedef struct packed {
    logic          last;
    logic [CB-1:0] y;
    logic [CB-1:0] x;
  } point_t;

  typedef struct packed {
    logic          run_last;
    logic          done;
    logic [CB-1:0] y;
    logic [CB-1:0] x;
  } emit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  spd_if #(.W(IN_W))  in_ch  (clk);
  spd_if #(.W(OUT_W)) out_ch (clk);
  spd_if #(.W(THR_W)) cfg_ch (clk);

  stroke_point_decimator uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [THR_W-1:0] thr_q;
  logic [2*CB-1:0]  head_q [SHORT_LIMIT_DEF];
  int unsigned      seen_q;
  logic [ACC_W-1:0] acc_q;
  logic [2*CB-1:0]  prev_q;
  logic [3:0]       marks_q;

  point_t pend_q[$];
  emit_t  emit_q[$];
  int     errors = 0;
  longint cycles = 0;
  bit     stall_go = 0;
  bit     stall_on = 0;

  function automatic logic [31:0] root_floor(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[31:0];
  endfunction

  function automatic logic [31:0] seg_len(logic [2*CB-1:0] a, logic [2*CB-1:0] b);
    logic [63:0] dx;
    logic [63:0] dy;
    dx = (a[CB-1:0] > b[CB-1:0]) ? a[CB-1:0] - b[CB-1:0] : b[CB-1:0] - a[CB-1:0];
    dy = (a[2*CB-1:CB] > b[2*CB-1:CB]) ? a[2*CB-1:CB] - b[2*CB-1:CB]
                                        : b[2*CB-1:CB] - a[2*CB-1:CB];
    return root_floor((dx*dx + dy*dy) << (2*FRAC_BITS_DEF));
  endfunction

  function automatic bit judge(logic [2*CB-1:0] p);
    logic [31:0] d;
    if (acc_q > thr_q) begin
      acc_q = '0;
      return 1'b1;
    end
    d = seg_len(prev_q, p);
    if (d >= ACC_MAX - acc_q) acc_q = ACC_MAX;
    else acc_q = ACC_W'(acc_q + d);
    return 1'b0;
  endfunction

  function automatic void push_emit(logic [2*CB-1:0] p, logic done);
    emit_t e;
    e.x = p[CB-1:0];
    e.y = p[2*CB-1:CB];
    e.done = done;
    e.run_last = 1'b0;
    emit_q = {emit_q, e};
  endfunction

  task automatic predict_point(point_t pt);
    logic [2*CB-1:0] p;
    int n0;
    int cnt;
    p = {pt.y, pt.x};
    n0 = emit_q.size();
    if (seen_q < SHORT_LIMIT_DEF) begin
      head_q[seen_q] = p;
      if (seen_q == 0) begin
        acc_q = '0;
        marks_q = 4'b0001;
      end else if (judge(p)) begin
        marks_q[seen_q] = 1'b1;
      end
      prev_q = p;
      seen_q++;
      if (pt.last) begin
        cnt = seen_q;
        if (cnt == 1) begin
          push_emit(head_q[0], 1'b1);
        end else begin
          push_emit(head_q[0], 1'b0);
          push_emit(head_q[(cnt-1)/2], 1'b0);
          push_emit(head_q[cnt-1], 1'b1);
        end
        seen_q = 0; acc_q = '0; marks_q = '0;
      end
    end else begin
      if (seen_q == SHORT_LIMIT_DEF) begin
        for (int i = 0; i < SHORT_LIMIT_DEF; i++)
          if (marks_q[i]) push_emit(head_q[i], 1'b0);
        seen_q = SHORT_LIMIT_DEF + 1;
      end
      if (judge(p)) push_emit(p, 1'b0);
      prev_q = p;
      if (pt.last) begin
        push_emit(p, 1'b1);
        seen_q = 0; acc_q = '0; marks_q = '0;
      end
    end
    if (emit_q.size() > n0) emit_q[emit_q.size()-1].run_last = 1'b1;
  endtask

  task automatic report(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  // driver
  int in_wait = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else if (in_ch.valid && !in_ch.ready) begin
    end else if (in_wait > 0) begin
      in_wait <= in_wait - 1;
      in_ch.valid <= 1'b0;
    end else if (pend_q.size() > 0 && !(in_ch.valid && pend_q.size() == 0)) begin
      in_ch.data <= pend_q.pop_front();
      in_ch.valid <= 1'b1;
      in_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // prediction at acceptance
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) predict_point(point_t'(in_ch.data));
  end

  // long receiver stall, counted in its own process
  initial begin
    wait (stall_go);
    @(posedge clk);
    stall_on <= 1'b1;
    repeat (300) @(posedge clk);
    stall_on <= 1'b0;
  end

  // monitor
  int out_wait = 0;
  always @(posedge clk) begin
    emit_t got;
    emit_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = emit_t'(out_ch.data);
        if (emit_q.size() == 0) begin
          report("word with nothing expected");
        end else begin
          want = emit_q.pop_front();
          if (got.x != want.x) report($sformatf("out_x %0d want %0d", got.x, want.x));
          if (got.y != want.y) report($sformatf("out_y %0d want %0d", got.y, want.y));
          if (got.done != want.done) report("stroke_done");
          if (got.run_last != want.run_last) report("run_last");
        end
      end
      if (stall_on) begin
        out_ch.ready <= 1'b0;
      end else if (out_wait > 0) begin
        out_wait <= out_wait - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (out_ch.valid && out_ch.ready)
          out_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic add_point(int x, int y, bit last);
    point_t pt;
    pt.x = CB'(x); pt.y = CB'(y); pt.last = last;
    pend_q = {pend_q, pt};
  endtask

  task automatic add_stroke(int n, int stepmax);
    int x;
    int y;
    x = $urandom_range(0, 4095);
    y = $urandom_range(0, 4095);
    for (int i = 0; i < n; i++) begin
      add_point(x, y, i == n-1);
      x = (x + $urandom_range(0, 2*stepmax) - stepmax) & 12'hfff;
      y = (y + $urandom_range(0, 2*stepmax) - stepmax) & 12'hfff;
    end
  endtask

  task automatic drain();
    while (pend_q.size() > 0 || in_ch.valid || emit_q.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_threshold(logic [THR_W-1:0] v);
    @(posedge clk);
    cfg_ch.data <= v;
    cfg_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    thr_q = v;
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int sent;
    int n;
    in_ch.valid = 1'b0; in_ch.data = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.data = '0;
    thr_q = THR_RESET; seen_q = 0; acc_q = '0; marks_q = '0; prev_q = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    // directed: single points, short strokes of every length, extremes
    add_point(0, 0, 1);
    add_point(4095, 4095, 1);
    add_point(0, 4095, 0); add_point(4095, 0, 1);
    add_point(1, 2, 0); add_point(1, 2, 0); add_point(3, 4, 1);
    add_point(0, 0, 0); add_point(10, 0, 0); add_point(20, 0, 0); add_point(30, 0, 1);
    // long strokes: marks in the head, steps at max distance
    add_point(0, 0, 0); add_point(4095, 4095, 0); add_point(0, 0, 0);
    add_point(4095, 4095, 0); add_point(0, 0, 0); add_point(2730, 1365, 1);
    add_point(5, 5, 0); add_point(6, 5, 0); add_point(7, 5, 0); add_point(8, 5, 0);
    add_point(9, 5, 0); add_point(100, 5, 1);
    drain();
    set_threshold(16'd0);
    add_stroke(7, 3); add_stroke(5, 0);
    drain();
    set_threshold(16'hffff);
    add_stroke(8, 4095);
    // receiver stalls long while points keep coming
    stall_go = 1'b1;
    add_stroke(6, 2000);
    drain();
    sent = 49;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: set_threshold(THR_RESET);
        1: set_threshold($urandom_range(0, 400));
        2: set_threshold(16'd1);
        default: set_threshold($urandom_range(0, 65535));
      endcase
      for (int k = 0; k < 5; k++) begin
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 9);
        if ($urandom_range(0, 9) == 0) add_stroke(n, 2048);
        else add_stroke(n, $urandom_range(1, 40));
        sent += n;
      end
      drain();
    end
    while (sent < 150) begin
      n = $urandom_range(1, 8);
      add_stroke(n, $urandom_range(1, 300));
      sent += n;
    end
    drain();
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: stroke_point_decimator.f
hdl/spd_pkg.sv
hdl/spd_if.sv
hdl/spd_datapath.sv
hdl/spd_ctrl.sv
hdl/stroke_point_decimator.sv
tb/tb.sv
